// ===== sv/tsrb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsrb_pkg;

    localparam logic [3:0] RESET_HOLD_DEPTH = 4'd4;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DRAIN  = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic        [15:0] frame_tag;
        logic signed [63:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic        [15:0] out_tag;
        logic signed [63:0] out_timestamp;
        logic               last;
    } t_out_item;

    // One stored frame as it moves along the chain.
    typedef struct packed {
        logic        [15:0] tag;
        logic signed [63:0] ts;
    } t_entry;

    // Broadcast to every cell of the chain in a cycle.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_INSERT,
        S_DRAIN
    } t_state;

endpackage

`default_nettype wire

// ===== sv/tsrb_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsrb_cell import tsrb_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_valid,
    input  wire t_entry    i_new,
    input  wire t_entry    i_prev,
    input  wire logic      i_prev_before,
    input  wire t_entry    i_next,
    output t_entry         o_entry,
    output logic           o_before
);

    t_entry r_entry;
    t_entry n_entry;

    // The new frame belongs at or ahead of this cell when this cell is empty or
    // holds a strictly later timestamp, so equal timestamps keep arrival order.
    assign o_before = !i_valid || (i_new.ts < r_entry.ts);
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert && o_before) begin
            n_entry = i_prev_before ? i_prev : i_new;
        end else if (i_ctl.pop) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== sv/timestamp_reorder_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Display-order reorder buffer. Frames enter in decode order and leave sorted by
// rising signed timestamp, equal timestamps in arrival order, once more than the
// hold depth (clamped to MAX_DEPTH) would be held. The store is a chain of
// MAX_DEPTH cells that all shift in the same cycle, so each operation steps
// through a small sequencer: an insert with room is accepted, then shifted in;
// one releasing the new frame itself stores nothing; one releasing the head goes
// through release, shift out and shift in; a drain emits every held frame and a
// flush clears them. busy is high while an item is at work. Each result appears
// on o_result for exactly one cycle with o_result_strobe; the receiver cannot
// stall it. Write hold_depth only while busy is low and no result is pending.
module timestamp_reorder_buffer import tsrb_pkg::*; #(
    parameter int unsigned MAX_DEPTH = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_in_item   i_item,
    output logic            o_result_strobe,
    output t_out_item       o_result,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [3:0] i_cfg_wr_data
);

    localparam int unsigned CW   = $clog2(MAX_DEPTH + 1);
    localparam int unsigned CMPW = (CW > 4) ? CW : 4;
    localparam logic [CMPW-1:0] DEPTH_CAP = CMPW'(MAX_DEPTH);

    t_state          r_state, n_state;
    logic   [CW-1:0] r_count, n_count;
    logic   [3:0]    r_hold;
    t_entry          r_new, n_new;
    logic            r_result_valid, n_result_valid;
    t_out_item       r_result, n_result;
    t_cell_ctl       w_ctl;

    t_entry          w_entry  [MAX_DEPTH];
    logic            w_before [MAX_DEPTH];

    logic            w_accept;
    logic [CMPW-1:0] w_depth;
    logic            w_room;
    logic            w_new_first;

    assign busy            = (r_state != S_IDLE);
    assign w_accept        = start && !busy;
    assign o_result_strobe = r_result_valid;
    assign o_result        = r_result;

    always_comb begin
        w_depth = (CMPW'(r_hold) > DEPTH_CAP) ? DEPTH_CAP : CMPW'(r_hold);
    end

    assign w_room      = CMPW'(r_count) < w_depth;
    assign w_new_first = (r_count == '0) || (i_item.timestamp < w_entry[0].ts);

    genvar g;
    generate
        for (g = 0; g < MAX_DEPTH; g++) begin : g_cell
            tsrb_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_valid       (CW'(g) < r_count),
                .i_new         (r_new),
                .i_prev        ((g == 0) ? r_new : w_entry[(g == 0) ? 0 : g - 1]),
                .i_prev_before ((g == 0) ? 1'b0 : w_before[(g == 0) ? 0 : g - 1]),
                .i_next        ((g == MAX_DEPTH - 1) ? w_entry[g]
                                : w_entry[(g == MAX_DEPTH - 1) ? g : g + 1]),
                .o_entry       (w_entry[g]),
                .o_before      (w_before[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_item.operation)
                        OP_INSERT: begin
                            if (w_room) begin
                                n_state = S_INSERT;
                            end else if (!w_new_first) begin
                                n_state = S_POP;
                            end
                        end
                        OP_DRAIN: begin
                            if (r_count != '0) begin
                                n_state = S_DRAIN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_POP:    n_state = S_INSERT;
            S_INSERT: n_state = S_IDLE;
            S_DRAIN: begin
                if (r_count == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count        = r_count;
        n_new          = r_new;
        n_result_valid = 1'b0;
        n_result       = r_result;
        w_ctl          = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_new.tag = i_item.frame_tag;
                    n_new.ts  = i_item.timestamp;
                    case (i_item.operation)
                        OP_INSERT: begin
                            if (!w_room) begin
                                n_result_valid = 1'b1;
                                n_result.last  = 1'b1;
                                if (w_new_first) begin
                                    n_result.out_tag       = i_item.frame_tag;
                                    n_result.out_timestamp = i_item.timestamp;
                                end else begin
                                    n_result.out_tag       = w_entry[0].tag;
                                    n_result.out_timestamp = w_entry[0].ts;
                                end
                            end
                        end
                        OP_FLUSH: n_count = '0;
                        default:  n_count = r_count;
                    endcase
                end
            end
            S_POP: begin
                w_ctl.pop = 1'b1;
                n_count   = r_count - CW'(1);
            end
            S_INSERT: begin
                w_ctl.insert = 1'b1;
                n_count      = r_count + CW'(1);
            end
            S_DRAIN: begin
                w_ctl.pop              = 1'b1;
                n_count                = r_count - CW'(1);
                n_result_valid         = 1'b1;
                n_result.out_tag       = w_entry[0].tag;
                n_result.out_timestamp = w_entry[0].ts;
                n_result.last          = (r_count == CW'(1));
            end
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_hold         <= RESET_HOLD_DEPTH;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_result_valid <= n_result_valid;
            if (i_cfg_wr_en) begin
                r_hold <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_new    <= n_new;
        r_result <= n_result;
    end

endmodule

`default_nettype wire
